// ===== sv/amd_pkg.sv =====
// ----------------------------------------------------------------------------
// amd_pkg: shared types and constants of the accelerometer motion detector
// Command codes, register map, field widths and the control word that drives
// the row of window cells.
// ----------------------------------------------------------------------------
package amd_pkg;

   // Field widths fixed by the interface.
   localparam int AXIS_W   = 16;
   localparam int MAG_W    = 16;
   localparam int CHANGE_W = 16;
   localparam int ACTIVE_W = 7;
   localparam int CMD_W    = 2;
   localparam int ERR_W    = 8;
   localparam int HOLD_W   = 16;

   // Square root unit: 32-bit radicand, one result bit per step.
   localparam int RAD_W      = 32;
   localparam int ROOT_W     = 16;
   localparam int ROOT_STEPS = 16;
   localparam int STEP_W     = 4;

   // Magnitude scaling by 980/1024.
   localparam int SCALE_W     = 10;
   localparam int SCALE_MUL   = 980;
   localparam int SCALE_SHIFT = 10;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR_WIN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_VIB = 2'd3;

   // Register map: register index is paddr[4:2].
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_REQUIRED_COUNT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STATIC_COUNT   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd4;

   // Register reset values.
   localparam logic [CHANGE_W-1:0] RST_DIFF_THRESHOLD = 16'd25;
   localparam logic [ACTIVE_W-1:0] RST_REQUIRED_COUNT = 7'd4;
   localparam logic [ACTIVE_W-1:0] RST_STATIC_COUNT   = 7'd3;
   localparam logic [HOLD_W-1:0]   RST_HOLD_TICKS     = 16'd180;
   localparam logic [ERR_W-1:0]    RST_ERROR_LIMIT    = 8'd100;

   // Control word broadcast to every window cell.
   typedef struct packed {
      logic step;   // every cell takes its neighbor's value
      logic clear;  // every cell goes to zero
   } amd_cell_ctrl_type;

endpackage

// ===== sv/amd_cell.sv =====
// ----------------------------------------------------------------------------
// amd_cell: one entry of the change window
// Holds one change value and takes the value of its neighbor on a step.
// ----------------------------------------------------------------------------
module amd_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  amd_pkg::amd_cell_ctrl_type        ctrl,
   input  logic [amd_pkg::CHANGE_W-1:0]      value_in,
   output logic [amd_pkg::CHANGE_W-1:0]      value_out
);

   logic [amd_pkg::CHANGE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         value_ff <= '0;
      end else if (ctrl.step) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;

endmodule

// ===== sv/amd_sqrt.sv =====
// ----------------------------------------------------------------------------
// amd_sqrt: iterative integer square root
// Digit-by-digit floor square root of a 32-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module amd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [amd_pkg::RAD_W-1:0]      radicand,
   output logic                           done,
   output logic [amd_pkg::ROOT_W-1:0]     root
);

   logic [amd_pkg::RAD_W-1:0]  rem_ff, rem_in;
   logic [amd_pkg::RAD_W-1:0]  root_ff, root_in;
   logic [amd_pkg::RAD_W-1:0]  bit_ff, bit_in;
   logic [amd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [amd_pkg::RAD_W-1:0]  trial;

   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = amd_pkg::RAD_W'(1) << (amd_pkg::RAD_W - 2);
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + 1'b1;
         if (step_ff == amd_pkg::STEP_W'(amd_pkg::ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[amd_pkg::ROOT_W-1:0];

endmodule

// ===== sv/accel_motion_detector.sv =====
// ----------------------------------------------------------------------------
// accel_motion_detector: vibration detector for a three-axis accelerometer
// Computes the scaled vector magnitude of each sample, keeps a window of
// magnitude changes and raises a held vibration flag.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and answers each with exactly
// one result word. A sample word passes through the sequencer states in
// order: the axes are squared and added through one shared multiplier, one
// axis at a time; the iterative square root unit runs from its start to its
// done strobe; the root is scaled by 980/1024; the change is entered into
// the window; and a window that is full is then rotated once around its row
// of cells so that the cell at the head is compared against diff_threshold
// at each step. Tick, clear-window and clear-flag words go straight to the
// finish state. A new word is accepted as soon as the previous one is
// finished, even if its result is still waiting in the output register.
// Configuration registers may be written only while no word is in flight.
module accel_motion_detector #(
   parameter int WINDOW_DEPTH = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Command channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [amd_pkg::CMD_W-1:0]            req_command,
   input  logic signed [amd_pkg::AXIS_W-1:0]    req_accel_x,
   input  logic signed [amd_pkg::AXIS_W-1:0]    req_accel_y,
   input  logic signed [amd_pkg::AXIS_W-1:0]    req_accel_z,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_vibrating,
   output logic [amd_pkg::MAG_W-1:0]            rsp_magnitude,
   output logic [amd_pkg::CHANGE_W-1:0]         rsp_change,
   output logic [amd_pkg::ACTIVE_W-1:0]         rsp_active_count,
   output logic                                 rsp_window_full,
   output logic                                 rsp_reinit_request,
   // Register port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [amd_pkg::ADDR_W-1:0]           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_WALK   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [amd_pkg::CHANGE_W-1:0] thr_ff;
   logic [amd_pkg::ACTIVE_W-1:0] req_cnt_ff;
   logic [amd_pkg::ACTIVE_W-1:0] stat_cnt_ff;
   logic [amd_pkg::HOLD_W-1:0]   hold_ticks_ff;
   logic [amd_pkg::ERR_W-1:0]    err_limit_ff;
   logic                         csr_write;
   logic [amd_pkg::REG_IDX_W-1:0] csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = paddr[amd_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= amd_pkg::RST_DIFF_THRESHOLD;
         req_cnt_ff    <= amd_pkg::RST_REQUIRED_COUNT;
         stat_cnt_ff   <= amd_pkg::RST_STATIC_COUNT;
         hold_ticks_ff <= amd_pkg::RST_HOLD_TICKS;
         err_limit_ff  <= amd_pkg::RST_ERROR_LIMIT;
      end else if (csr_write) begin
         case (csr_idx)
            amd_pkg::REG_DIFF_THRESHOLD: thr_ff      <= pwdata[amd_pkg::CHANGE_W-1:0];
            amd_pkg::REG_REQUIRED_COUNT: req_cnt_ff  <= pwdata[amd_pkg::ACTIVE_W-1:0];
            amd_pkg::REG_STATIC_COUNT:   stat_cnt_ff <= pwdata[amd_pkg::ACTIVE_W-1:0];
            amd_pkg::REG_HOLD_TICKS:     hold_ticks_ff <= pwdata[amd_pkg::HOLD_W-1:0];
            amd_pkg::REG_ERROR_LIMIT:    err_limit_ff  <= pwdata[amd_pkg::ERR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         amd_pkg::REG_DIFF_THRESHOLD: prdata = 32'(thr_ff);
         amd_pkg::REG_REQUIRED_COUNT: prdata = 32'(req_cnt_ff);
         amd_pkg::REG_STATIC_COUNT:   prdata = 32'(stat_cnt_ff);
         amd_pkg::REG_HOLD_TICKS:     prdata = 32'(hold_ticks_ff);
         amd_pkg::REG_ERROR_LIMIT:    prdata = 32'(err_limit_ff);
         default:                     prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and sequencer registers
   // ------------------------------------------------------------------------
   logic [2:0]                   state_ff, state_in;
   logic [amd_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [amd_pkg::AXIS_W-1:0]   ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [1:0]                   sq_cnt_ff, sq_cnt_in;
   logic [amd_pkg::RAD_W-1:0]    sum_ff, sum_in;
   logic [amd_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic                         root_nz_ff, root_nz_in;
   logic [amd_pkg::CHANGE_W-1:0] change_ff, change_in;
   logic [amd_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [FILL_W-1:0]            walk_cnt_ff, walk_cnt_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [amd_pkg::MAG_W-1:0]    last_mag_ff, last_mag_in;
   logic                         last_mag_valid_ff, last_mag_valid_in;
   logic [amd_pkg::AXIS_W-1:0]   last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [amd_pkg::AXIS_W-1:0]   last_z_ff, last_z_in;
   logic [amd_pkg::ERR_W-1:0]    err_ff, err_in;
   logic                         vib_ff, vib_in;
   logic [amd_pkg::HOLD_W-1:0]   hold_ff, hold_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_vib_ff, rsp_vib_in;
   logic [amd_pkg::MAG_W-1:0]    rsp_mag_ff, rsp_mag_in;
   logic [amd_pkg::CHANGE_W-1:0] rsp_change_ff, rsp_change_in;
   logic [amd_pkg::ACTIVE_W-1:0] rsp_active_ff, rsp_active_in;
   logic                         rsp_full_ff, rsp_full_in;
   logic                         rsp_reinit_ff, rsp_reinit_in;

   // Combinational helpers.
   logic                         req_fire;
   logic                         done_go;
   logic [amd_pkg::AXIS_W-1:0]   axis_raw;
   logic [amd_pkg::AXIS_W-1:0]   axis_abs;
   logic [amd_pkg::RAD_W-1:0]    axis_sq;
   logic                         sqrt_start;
   logic                         sqrt_done;
   logic [amd_pkg::ROOT_W-1:0]   sqrt_root;
   logic [amd_pkg::ROOT_W+amd_pkg::SCALE_W-1:0] scaled;
   logic [amd_pkg::CHANGE_W-1:0] diff;
   logic                         window_full;
   logic                         detect;
   logic                         same_xyz;
   logic [amd_pkg::ERR_W+1:0]    errs;
   logic                         reinit;
   logic [amd_pkg::HOLD_W-1:0]   hold_dec;

   // Window of change values: a row of cells. Cell 0 is the head; on every
   // step each cell takes the value of the cell above it and the top cell
   // takes either the new change (entering a sample) or the head value
   // (rotating the window past the comparator).
   amd_pkg::amd_cell_ctrl_type   cell_ctrl;
   logic [amd_pkg::CHANGE_W-1:0] cell_q [WINDOW_DEPTH];
   logic [amd_pkg::CHANGE_W-1:0] tail_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign done_go     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign window_full = (fill_ff == FILL_W'(WINDOW_DEPTH));

   // One squarer shared by the three axes, one axis per cycle.
   always_comb begin
      case (sq_cnt_ff)
         2'd0:    axis_raw = ax_ff;
         2'd1:    axis_raw = ay_ff;
         default: axis_raw = az_ff;
      endcase
   end
   assign axis_abs = axis_raw[amd_pkg::AXIS_W-1] ? (~axis_raw + 1'b1) : axis_raw;
   assign axis_sq  = amd_pkg::RAD_W'(axis_abs) * amd_pkg::RAD_W'(axis_abs);

   // The root unit starts on the cycle the last square is added.
   assign sqrt_start = (state_ff == ST_SQUARE) && (sq_cnt_ff == 2'd2);

   amd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_in),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign scaled = sqrt_root * amd_pkg::SCALE_W'(amd_pkg::SCALE_MUL);

   // Change against the previous magnitude; zero for the first one.
   always_comb begin
      if (!last_mag_valid_ff) begin
         diff = '0;
      end else if (mag_ff > last_mag_ff) begin
         diff = mag_ff - last_mag_ff;
      end else begin
         diff = last_mag_ff - mag_ff;
      end
   end

   assign tail_in         = (state_ff == ST_SHIFT) ? diff : cell_q[0];
   assign cell_ctrl.step  = ((state_ff == ST_SHIFT) && root_nz_ff) || (state_ff == ST_WALK);
   assign cell_ctrl.clear = done_go && (cmd_ff == amd_pkg::CMD_CLEAR_WIN);

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      amd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .value_in  ((i == WINDOW_DEPTH - 1) ? tail_in : cell_q[(i + 1) % WINDOW_DEPTH]),
         .value_out (cell_q[i])
      );
   end

   // Decisions taken when the word finishes.
   assign detect   = root_nz_ff && window_full && (active_ff > stat_cnt_ff) &&
                     (active_ff >= req_cnt_ff);
   assign same_xyz = (ax_ff == last_x_ff) && (ay_ff == last_y_ff) && (az_ff == last_z_ff);
   assign errs     = (root_nz_ff ? '0 : ((amd_pkg::ERR_W + 2)'(err_ff) + 1'b1)) +
                     (amd_pkg::ERR_W + 2)'(same_xyz) + 1'b1;
   assign reinit   = (errs >= (amd_pkg::ERR_W + 2)'(err_limit_ff));
   assign hold_dec = (hold_ff != '0) ? (hold_ff - 1'b1) : hold_ff;

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      ax_in             = ax_ff;
      ay_in             = ay_ff;
      az_in             = az_ff;
      sq_cnt_in         = sq_cnt_ff;
      sum_in            = sum_ff;
      mag_in            = mag_ff;
      root_nz_in        = root_nz_ff;
      change_in         = change_ff;
      active_in         = active_ff;
      walk_cnt_in       = walk_cnt_ff;
      fill_in           = fill_ff;
      last_mag_in       = last_mag_ff;
      last_mag_valid_in = last_mag_valid_ff;
      last_x_in         = last_x_ff;
      last_y_in         = last_y_ff;
      last_z_in         = last_z_ff;
      err_in            = err_ff;
      vib_in            = vib_ff;
      hold_in           = hold_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_vib_in        = rsp_vib_ff;
      rsp_mag_in        = rsp_mag_ff;
      rsp_change_in     = rsp_change_ff;
      rsp_active_in     = rsp_active_ff;
      rsp_full_in       = rsp_full_ff;
      rsp_reinit_in     = rsp_reinit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_command;
               ax_in       = req_accel_x;
               ay_in       = req_accel_y;
               az_in       = req_accel_z;
               sq_cnt_in   = '0;
               sum_in      = '0;
               mag_in      = '0;
               root_nz_in  = 1'b0;
               change_in   = '0;
               active_in   = '0;
               walk_cnt_in = '0;
               state_in    = (req_command == amd_pkg::CMD_SAMPLE) ? ST_SQUARE : ST_DONE;
            end
         end
         ST_SQUARE: begin
            sum_in    = sum_ff + axis_sq;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == 2'd2) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mag_in     = scaled[amd_pkg::SCALE_SHIFT +: amd_pkg::MAG_W];
            root_nz_in = (sqrt_root != '0);
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = ST_DONE;
            if (root_nz_ff) begin
               change_in         = diff;
               last_mag_in       = mag_ff;
               last_mag_valid_in = 1'b1;
               if (!window_full) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (window_full || (fill_ff == FILL_W'(WINDOW_DEPTH - 1))) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (cell_q[0] >= thr_ff) begin
               active_in = active_ff + 1'b1;
            end
            walk_cnt_in = walk_cnt_ff + 1'b1;
            if (walk_cnt_ff == FILL_W'(WINDOW_DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               rsp_reinit_in = 1'b0;
               case (cmd_ff)
                  amd_pkg::CMD_SAMPLE: begin
                     if (detect) begin
                        vib_in  = 1'b1;
                        hold_in = hold_ticks_ff;
                     end
                     last_x_in     = ax_ff;
                     last_y_in     = ay_ff;
                     last_z_in     = az_ff;
                     err_in        = reinit ? '0 : errs[amd_pkg::ERR_W-1:0];
                     rsp_reinit_in = reinit;
                  end
                  amd_pkg::CMD_TICK: begin
                     hold_in = hold_dec;
                     if (hold_dec == '0) begin
                        vib_in = 1'b0;
                     end
                  end
                  amd_pkg::CMD_CLEAR_VIB: begin
                     vib_in  = 1'b0;
                     hold_in = '0;
                  end
                  default: ;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_vib_in    = vib_in;
               rsp_mag_in    = mag_ff;
               rsp_change_in = change_ff;
               rsp_active_in = active_ff;
               rsp_full_in   = window_full;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         sq_cnt_ff         <= '0;
         walk_cnt_ff       <= '0;
         root_nz_ff        <= 1'b0;
         active_ff         <= '0;
         change_ff         <= '0;
         mag_ff            <= '0;
         fill_ff           <= '0;
         last_mag_ff       <= '0;
         last_mag_valid_ff <= 1'b0;
         last_x_ff         <= '0;
         last_y_ff         <= '0;
         last_z_ff         <= '0;
         err_ff            <= '0;
         vib_ff            <= 1'b0;
         hold_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         sq_cnt_ff         <= sq_cnt_in;
         walk_cnt_ff       <= walk_cnt_in;
         root_nz_ff        <= root_nz_in;
         active_ff         <= active_in;
         change_ff         <= change_in;
         mag_ff            <= mag_in;
         fill_ff           <= fill_in;
         last_mag_ff       <= last_mag_in;
         last_mag_valid_ff <= last_mag_valid_in;
         last_x_ff         <= last_x_in;
         last_y_ff         <= last_y_in;
         last_z_ff         <= last_z_in;
         err_ff            <= err_in;
         vib_ff            <= vib_in;
         hold_ff           <= hold_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      az_ff         <= az_in;
      sum_ff        <= sum_in;
      rsp_vib_ff    <= rsp_vib_in;
      rsp_mag_ff    <= rsp_mag_in;
      rsp_change_ff <= rsp_change_in;
      rsp_active_ff <= rsp_active_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_reinit_ff <= rsp_reinit_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vibrating      = rsp_vib_ff;
   assign rsp_magnitude      = rsp_mag_ff;
   assign rsp_change         = rsp_change_ff;
   assign rsp_active_count   = rsp_active_ff;
   assign rsp_window_full    = rsp_full_ff;
   assign rsp_reinit_request = rsp_reinit_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_walk_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> window_full)
      else $error("window walk started on a window that is not full");

   a_root_in_root_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside the root state");

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_active_ff <= amd_pkg::ACTIVE_W'(WINDOW_DEPTH)))
      else $error("active count exceeds the window depth");

   a_reinit_clears_errors: assert property (@(posedge clock) disable iff (reset)
      (done_go && (cmd_ff == amd_pkg::CMD_SAMPLE) && reinit) |=> (err_ff == '0))
      else $error("error counter not cleared on a re-init request");

   a_vib_needs_hold: assert property (@(posedge clock) disable iff (reset)
      (done_go && (cmd_ff == amd_pkg::CMD_TICK)) |=> (!vib_ff || (hold_ff != '0)))
      else $error("vibration flag left set with an empty hold counter");

endmodule
